// ----- sv/collinear_segment_merger_defines.svh -----
// Assertion macros shared by the collinear segment merger RTL.
// Included by csm_div, csm_out_queue and collinear_segment_merger; no dependencies.
`ifndef COLLINEAR_SEGMENT_MERGER_DEFINES_SVH
`define COLLINEAR_SEGMENT_MERGER_DEFINES_SVH

`ifndef SYNTHESIS
`define CSM_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define CSM_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) ante |=> cons) else $error(msg);
`else
`define CSM_ASSERT(name, prop, msg)
`define CSM_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

// ----- sv/csm_pkg.sv -----
// Types, widths and constants of the collinear segment merger.
// No dependencies; imported by every module of the block.
package csm_pkg;

   localparam int SEG_W    = 16;
   localparam int HELD_W   = 24;
   localparam int SLOPE_W  = 32;
   localparam int FRAC_W   = 16;
   localparam int DVD_W    = HELD_W + FRAC_W;
   localparam int STEP_W   = $clog2(DVD_W);
   localparam int TOL_W    = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [TOL_W-1:0]   TOL_RESET = TOL_W'(656);
   localparam logic [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
   localparam logic [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};
   localparam logic [HELD_W-1:0]  HELD_MAX  = {1'b0, {(HELD_W-1){1'b1}}};
   localparam logic [HELD_W-1:0]  HELD_MIN  = {1'b1, {(HELD_W-1){1'b0}}};

   typedef struct packed {
      logic signed [SEG_W-1:0] seg_dx;
      logic signed [SEG_W-1:0] seg_dy;
      logic                    seg_last;
   } csm_req_type;

   typedef struct packed {
      logic signed [HELD_W-1:0] out_dx;
      logic signed [HELD_W-1:0] out_dy;
      logic                     out_last;
   } csm_rsp_type;

   typedef struct packed {
      logic              start;
      logic [HELD_W-1:0] num;
      logic [HELD_W-1:0] den;
   } csm_div_req_type;

   typedef struct packed {
      logic               done;
      logic [SLOPE_W-1:0] quot;
   } csm_div_rsp_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      csm_rsp_type       first;
      csm_rsp_type       second;
   } csm_push_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_NEW,
      ST_DIV_HELD,
      ST_COMPARE,
      ST_FINISH
   } csm_state_type;

   typedef enum logic {
      AXIS_X,
      AXIS_Y
   } csm_axis_type;

endpackage

// ----- sv/csm_div.sv -----
// Shared radix-2 restoring divider: saturated signed Q16.16 quotient num/den.
// Depends on csm_pkg and collinear_segment_merger_defines.svh.
`include "collinear_segment_merger_defines.svh"

module csm_div
   import csm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  csm_div_req_type div_req,
   output csm_div_rsp_type div_rsp
);

   logic              busy_ff, busy_in;
   logic              fin_ff, fin_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [HELD_W-1:0] rem_ff, rem_in;
   logic [HELD_W-1:0] den_ff, den_in;
   logic              neg_ff, neg_in;

   logic [HELD_W+1:0] diff;
   logic              ge;
   logic [HELD_W-1:0] num_mag;
   logic [HELD_W-1:0] den_mag;
   logic              over_pos;
   logic              over_neg;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         step_ff <= step_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      num_mag = div_req.num[HELD_W-1] ? (~div_req.num + 1'b1) : div_req.num;
      den_mag = div_req.den[HELD_W-1] ? (~div_req.den + 1'b1) : div_req.den;
      diff    = {1'b0, rem_ff, dvd_ff[DVD_W-1]} - {2'b00, den_ff};
      ge      = ~diff[HELD_W+1];

      busy_in = busy_ff;
      fin_in  = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;

      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = {num_mag, {FRAC_W{1'b0}}};
         rem_in  = '0;
         den_in  = den_mag;
         neg_in  = div_req.num[HELD_W-1] ^ div_req.den[HELD_W-1];
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[DVD_W-2:0], ge};
         rem_in  = ge ? diff[HELD_W-1:0] : {rem_ff[HELD_W-2:0], dvd_ff[DVD_W-1]};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
   end

   always_comb begin
      over_pos = |dvd_ff[DVD_W-1:SLOPE_W-1];
      over_neg = (|dvd_ff[DVD_W-1:SLOPE_W])
               || (dvd_ff[SLOPE_W-1] && (|dvd_ff[SLOPE_W-2:0]));
      div_rsp.done = fin_ff;
      if (neg_ff) begin
         div_rsp.quot = over_neg ? SLOPE_MIN : (~dvd_ff[SLOPE_W-1:0] + 1'b1);
      end else begin
         div_rsp.quot = over_pos ? SLOPE_MAX : dvd_ff[SLOPE_W-1:0];
      end
   end

   `CSM_ASSERT(a_div_start_idle, div_req.start |-> !busy_ff, "divider started while busy")
   `CSM_ASSERT_NEXT(a_div_done_pulse, fin_ff, !fin_ff, "divider done not a pulse")

endmodule

// ----- sv/csm_out_queue.sv -----
// Two-entry result queue; takes up to two results per transfer, releases one.
// Depends on csm_pkg and collinear_segment_merger_defines.svh.
`include "collinear_segment_merger_defines.svh"

module csm_out_queue
   import csm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  csm_push_type      push,
   output logic [QCNT_W-1:0] free,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output csm_rsp_type       rsp_data
);

   csm_rsp_type       ent_ff [QUEUE_DEPTH];
   csm_rsp_type       ent_in [QUEUE_DEPTH];
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic [QCNT_W-1:0] cnt_mid;
   logic              pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      ent_ff <= ent_in;
   end

   always_comb begin
      pop     = rsp_valid && !rsp_stall;
      ent_in  = ent_ff;
      cnt_mid = cnt_ff;
      if (pop) begin
         ent_in[0] = ent_ff[1];
         cnt_mid   = cnt_ff - 1'b1;
      end
      case (push.count)
         QCNT_W'(1): begin
            ent_in[cnt_mid[0]] = push.first;
         end
         QCNT_W'(2): begin
            ent_in[0] = push.first;
            ent_in[1] = push.second;
         end
         default: begin
         end
      endcase
      cnt_in = cnt_mid + push.count;
   end

   assign free      = QCNT_W'(QUEUE_DEPTH) - cnt_ff;
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = ent_ff[0];

   `CSM_ASSERT(a_q_no_overflow, push.count <= free, "result queue overflow")
   `CSM_ASSERT(a_q_count_range, cnt_ff <= QCNT_W'(QUEUE_DEPTH), "result queue count out of range")

endmodule

// ----- sv/collinear_segment_merger.sv -----
// Collinear segment merger: an incoming segment costs two slope divisions on one shared
// radix-2 divider (quotient steps, then a finish step, each), so an item with a
// comparable axis waits for both divisions before the next transfer can be taken; an item
// with nothing held, or no comparable axis, skips the divider. The divider's step count sets the
// rate. Results wait in a two-entry queue, so a stalled result side blocks input only
// once the queue lacks room for an item's results. slope_tolerance is written via csr_.
// Depends on csm_pkg, csm_div, csm_out_queue and collinear_segment_merger_defines.svh.
`include "collinear_segment_merger_defines.svh"

module collinear_segment_merger
   import csm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  csm_req_type      req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output csm_rsp_type      rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [TOL_W-1:0] csr_data
);

   csm_state_type      state_ff, state_in;
   logic [TOL_W-1:0]   tol_ff;
   logic [HELD_W-1:0]  held_dx_ff, held_dx_in;
   logic [HELD_W-1:0]  held_dy_ff, held_dy_in;
   logic               held_valid_ff, held_valid_in;
   csm_req_type        in_ff, in_in;
   csm_axis_type       axis_ff, axis_in;
   logic               merge_ff, merge_in;
   logic [SLOPE_W-1:0] m_new_ff, m_new_in;
   logic [SLOPE_W-1:0] m_held_ff, m_held_in;

   csm_div_req_type    div_req;
   csm_div_rsp_type    div_rsp;
   csm_push_type       push;
   logic [QCNT_W-1:0]  free;

   logic [HELD_W-1:0]  req_dx_ext, req_dy_ext;
   logic [HELD_W-1:0]  in_dx_ext, in_dy_ext;
   logic               x_ok, y_ok;
   logic signed [SLOPE_W+1:0] diff, diff_neg, tol_ext;
   logic [HELD_W:0]    sum_dx, sum_dy;
   logic [HELD_W-1:0]  sat_dx, sat_dy;
   logic [HELD_W-1:0]  next_dx, next_dy;
   logic               displace;
   logic [QCNT_W-1:0]  n_push;

   csm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   csm_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tol_ff        <= TOL_RESET;
         held_dx_ff    <= '0;
         held_dy_ff    <= '0;
         held_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_dx_ff    <= held_dx_in;
         held_dy_ff    <= held_dy_in;
         held_valid_ff <= held_valid_in;
         if (csr_valid && csr_ready) begin
            tol_ff <= csr_data;
         end
      end
      in_ff     <= in_in;
      axis_ff   <= axis_in;
      merge_ff  <= merge_in;
      m_new_ff  <= m_new_in;
      m_held_ff <= m_held_in;
   end

   always_comb begin
      req_dx_ext = {{(HELD_W-SEG_W){req_data.seg_dx[SEG_W-1]}}, req_data.seg_dx};
      req_dy_ext = {{(HELD_W-SEG_W){req_data.seg_dy[SEG_W-1]}}, req_data.seg_dy};
      in_dx_ext  = {{(HELD_W-SEG_W){in_ff.seg_dx[SEG_W-1]}}, in_ff.seg_dx};
      in_dy_ext  = {{(HELD_W-SEG_W){in_ff.seg_dy[SEG_W-1]}}, in_ff.seg_dy};
      x_ok = (req_data.seg_dx != '0) && (held_dx_ff != '0);
      y_ok = (req_data.seg_dy != '0) && (held_dy_ff != '0);

      diff     = {{2{m_new_ff[SLOPE_W-1]}}, m_new_ff} - {{2{m_held_ff[SLOPE_W-1]}}, m_held_ff};
      diff_neg = -diff;
      tol_ext  = {2'b00, tol_ff};

      sum_dx = {held_dx_ff[HELD_W-1], held_dx_ff} + {in_dx_ext[HELD_W-1], in_dx_ext};
      sum_dy = {held_dy_ff[HELD_W-1], held_dy_ff} + {in_dy_ext[HELD_W-1], in_dy_ext};
      sat_dx = (sum_dx[HELD_W] != sum_dx[HELD_W-1])
             ? (sum_dx[HELD_W] ? HELD_MIN : HELD_MAX) : sum_dx[HELD_W-1:0];
      sat_dy = (sum_dy[HELD_W] != sum_dy[HELD_W-1])
             ? (sum_dy[HELD_W] ? HELD_MIN : HELD_MAX) : sum_dy[HELD_W-1:0];

      displace = held_valid_ff && !merge_ff;
      next_dx  = (held_valid_ff && merge_ff) ? sat_dx : in_dx_ext;
      next_dy  = (held_valid_ff && merge_ff) ? sat_dy : in_dy_ext;
      n_push   = QCNT_W'(displace) + QCNT_W'(in_ff.seg_last);
   end

   always_comb begin
      state_in      = state_ff;
      held_dx_in    = held_dx_ff;
      held_dy_in    = held_dy_ff;
      held_valid_in = held_valid_ff;
      in_in         = in_ff;
      axis_in       = axis_ff;
      merge_in      = merge_ff;
      m_new_in      = m_new_ff;
      m_held_in     = m_held_ff;
      req_stall     = (state_ff != ST_IDLE);
      div_req       = '0;
      push          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               in_in    = req_data;
               merge_in = 1'b0;
               axis_in  = x_ok ? AXIS_X : AXIS_Y;
               if (held_valid_ff && (x_ok || y_ok)) begin
                  div_req.start = 1'b1;
                  div_req.num   = x_ok ? req_dy_ext : req_dx_ext;
                  div_req.den   = x_ok ? req_dx_ext : req_dy_ext;
                  state_in      = ST_DIV_NEW;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_DIV_NEW: begin
            if (div_rsp.done) begin
               m_new_in      = div_rsp.quot;
               div_req.start = 1'b1;
               div_req.num   = (axis_ff == AXIS_X) ? held_dy_ff : held_dx_ff;
               div_req.den   = (axis_ff == AXIS_X) ? held_dx_ff : held_dy_ff;
               state_in      = ST_DIV_HELD;
            end
         end
         ST_DIV_HELD: begin
            if (div_rsp.done) begin
               m_held_in = div_rsp.quot;
               state_in  = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            merge_in = (diff < tol_ext) && (diff_neg < tol_ext);
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (n_push <= free) begin
               push.count = n_push;
               if (displace) begin
                  push.first  = '{out_dx: held_dx_ff, out_dy: held_dy_ff, out_last: 1'b0};
                  push.second = '{out_dx: next_dx, out_dy: next_dy, out_last: 1'b1};
               end else begin
                  push.first  = '{out_dx: next_dx, out_dy: next_dy, out_last: 1'b1};
               end
               if (in_ff.seg_last) begin
                  held_dx_in    = '0;
                  held_dy_in    = '0;
                  held_valid_in = 1'b0;
               end else begin
                  held_dx_in    = next_dx;
                  held_dy_in    = next_dy;
                  held_valid_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `CSM_ASSERT(a_empty_hold_zero, !held_valid_ff |-> (held_dx_ff == '0 && held_dy_ff == '0),
      "held vector not cleared while nothing is held")

endmodule
